[hw/rtl/zip_local_header_parser_top_macros.svh]
// ----------------------------------------------------------------------------
// zip_local_header_parser_top_macros.svh
// Assertion macros used by the ZIP local header parser RTL.
// ----------------------------------------------------------------------------
`ifndef ZIP_LOCAL_HEADER_PARSER_TOP_MACROS_SVH
`define ZIP_LOCAL_HEADER_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define ZLHP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define ZLHP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/zlhp_pkg.sv]
// ----------------------------------------------------------------------------
// zlhp_pkg
// Types and constants of the ZIP local header parser.
// ----------------------------------------------------------------------------
package zlhp_pkg;

    localparam logic [31:0] LOC_SIGNATURE  = 32'h0403_4b50;
    localparam logic [31:0] DESC_SIGNATURE = 32'h0807_4b50;
    localparam logic [7:0]  PREFIX_MARK    = 8'h30;
    localparam logic [31:0] PREFIX_SKIP    = 32'd124;
    localparam logic [4:0]  SIG_LAST       = 5'd3;
    localparam logic [4:0]  DESC_LAST      = 5'd19;
    localparam logic [4:0]  HDR_FLAGS      = 5'd3;
    localparam logic [4:0]  HDR_METHOD     = 5'd5;
    localparam logic [4:0]  HDR_PACKED     = 5'd17;
    localparam logic [4:0]  HDR_PLAIN      = 5'd21;
    localparam logic [4:0]  HDR_NAME_LEN   = 5'd23;
    localparam logic [4:0]  HDR_EXTRA_LEN  = 5'd25;
    localparam logic [15:0] METHOD_MAX     = 16'd8;
    localparam logic [15:0] METHOD_IMPLODE = 16'd6;
    localparam logic [15:0] METHOD_RSVD    = 16'd7;
    localparam logic [7:0]  CHAR_SLASH     = 8'h2f;
    localparam logic [7:0]  CHAR_BSLASH    = 8'h5c;

    localparam logic [3:0] CODE_IMPLODE_NOLIT4 = 4'd6;
    localparam logic [3:0] CODE_IMPLODE_NOLIT8 = 4'd7;
    localparam logic [3:0] CODE_IMPLODE_LIT4   = 4'd8;
    localparam logic [3:0] CODE_IMPLODE_LIT8   = 4'd9;
    localparam logic [3:0] CODE_RESERVED       = 4'd10;
    localparam logic [3:0] CODE_DEFLATED       = 4'd11;

    localparam logic CFG_STREAM_MODE = 1'b0;
    localparam logic CFG_BASE_OFFSET = 1'b1;

    localparam int TDATA_W = 128;

    typedef enum logic [2:0] {
        PH_SIG,
        PH_DESC,
        PH_PREFIX,
        PH_HDR,
        PH_NAME,
        PH_EXTRA,
        PH_DATA
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ENTRY,
        KIND_DATA,
        KIND_STOP
    } t_kind;

    typedef enum logic [1:0] {
        STOP_BAD_SIG,
        STOP_METHOD,
        STOP_NAME_LONG,
        STOP_STREAM_END
    } t_stop;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  method_code;
        logic [31:0] packed_size;
        logic [31:0] plain_size;
        logic [12:0] name_length;
        logic [31:0] data_offset;
        logic [7:0]  data_byte;
        logic        last_data;
        t_stop       stop_reason;
    } t_result;

endpackage

[hw/rtl/zlhp_parser.sv]
// ----------------------------------------------------------------------------
// zlhp_parser
// Header state machine: consumes one archive byte per accepted word and
// forms at most one result word in the same cycle.
// ----------------------------------------------------------------------------
`include "zip_local_header_parser_top_macros.svh"

module zlhp_parser #(
    parameter int NAME_LIMIT = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wen,
    input  logic               i_cfg_addr,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    output logic               o_res_valid,
    output zlhp_pkg::t_result  o_res
);

    localparam int NAME_W = $clog2(NAME_LIMIT);

    zlhp_pkg::t_phase    r_phase, n_phase;
    logic [4:0]          r_count, n_count;
    logic [31:0]         r_shift, n_shift;
    logic [1:0]          r_flags, n_flags;
    logic [3:0]          r_method, n_method;
    logic [31:0]         r_packed, n_packed;
    logic [31:0]         r_plain, n_plain;
    logic [NAME_W-1:0]   r_name_len, n_name_len;
    logic [15:0]         r_extra, n_extra;
    logic [31:0]         r_remaining, n_remaining;
    logic [31:0]         r_pos, n_pos;
    logic                r_prefix_ok, n_prefix_ok;
    logic                r_halted, n_halted;
    logic                r_stream_mode;
    logic [31:0]         r_base_offset;

    logic [31:0]         sh;
    logic                do_finish;
    logic                do_after;
    logic                is_dir;
    logic [15:0]         fin_extra;

    function automatic logic [3:0] map_method(input logic [15:0] m, input logic [1:0] fl);
        logic [3:0] code;
        if (m <= 16'd5) begin
            code = m[3:0];
        end else if (m == zlhp_pkg::METHOD_IMPLODE) begin
            case (fl)
                2'b00:   code = zlhp_pkg::CODE_IMPLODE_NOLIT4;
                2'b01:   code = zlhp_pkg::CODE_IMPLODE_NOLIT8;
                2'b10:   code = zlhp_pkg::CODE_IMPLODE_LIT4;
                default: code = zlhp_pkg::CODE_IMPLODE_LIT8;
            endcase
        end else if (m == zlhp_pkg::METHOD_RSVD) begin
            code = zlhp_pkg::CODE_RESERVED;
        end else begin
            code = zlhp_pkg::CODE_DEFLATED;
        end
        return code;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_mode <= 1'b0;
            r_base_offset <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_addr)
                zlhp_pkg::CFG_STREAM_MODE: r_stream_mode <= i_cfg_data[0];
                zlhp_pkg::CFG_BASE_OFFSET: r_base_offset <= i_cfg_data;
                default:                   r_stream_mode <= r_stream_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= zlhp_pkg::PH_SIG;
            r_count     <= '0;
            r_shift     <= '0;
            r_flags     <= '0;
            r_method    <= '0;
            r_packed    <= '0;
            r_plain     <= '0;
            r_name_len  <= '0;
            r_extra     <= '0;
            r_remaining <= '0;
            r_pos       <= '0;
            r_prefix_ok <= 1'b1;
            r_halted    <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_shift     <= n_shift;
            r_flags     <= n_flags;
            r_method    <= n_method;
            r_packed    <= n_packed;
            r_plain     <= n_plain;
            r_name_len  <= n_name_len;
            r_extra     <= n_extra;
            r_remaining <= n_remaining;
            r_pos       <= n_pos;
            r_prefix_ok <= n_prefix_ok;
            r_halted    <= n_halted;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_shift     = r_shift;
        n_flags     = r_flags;
        n_method    = r_method;
        n_packed    = r_packed;
        n_plain     = r_plain;
        n_name_len  = r_name_len;
        n_extra     = r_extra;
        n_remaining = r_remaining;
        n_pos       = r_pos;
        n_prefix_ok = r_prefix_ok;
        n_halted    = r_halted;
        o_res_valid = 1'b0;
        o_res       = '0;
        do_finish   = 1'b0;
        do_after    = 1'b0;
        fin_extra   = r_extra;
        sh          = {i_byte, r_shift[31:8]};
        is_dir      = (r_packed == 32'd0) && (r_name_len != '0) &&
                      ((i_byte == zlhp_pkg::CHAR_SLASH) || (i_byte == zlhp_pkg::CHAR_BSLASH));

        if (i_valid && !r_halted) begin
            if (i_end) begin
                n_halted          = 1'b1;
                o_res_valid       = 1'b1;
                o_res.kind        = zlhp_pkg::KIND_STOP;
                o_res.stop_reason = zlhp_pkg::STOP_STREAM_END;
            end else begin
                n_pos   = r_pos + 32'd1;
                n_shift = sh;
                case (r_phase)
                    zlhp_pkg::PH_SIG: begin
                        if (r_count != zlhp_pkg::SIG_LAST) begin
                            n_count = r_count + 5'd1;
                        end else begin
                            n_count = '0;
                            if (sh == zlhp_pkg::DESC_SIGNATURE) begin
                                n_phase = zlhp_pkg::PH_DESC;
                            end else if (r_prefix_ok && sh[7:0] == zlhp_pkg::PREFIX_MARK) begin
                                n_prefix_ok = 1'b0;
                                n_phase     = zlhp_pkg::PH_PREFIX;
                                n_remaining = zlhp_pkg::PREFIX_SKIP;
                            end else if (sh != zlhp_pkg::LOC_SIGNATURE) begin
                                n_halted          = 1'b1;
                                o_res_valid       = 1'b1;
                                o_res.kind        = zlhp_pkg::KIND_STOP;
                                o_res.stop_reason = zlhp_pkg::STOP_BAD_SIG;
                            end else begin
                                n_phase = zlhp_pkg::PH_HDR;
                            end
                        end
                    end
                    zlhp_pkg::PH_DESC: begin
                        if (r_count != zlhp_pkg::DESC_LAST) begin
                            n_count = r_count + 5'd1;
                        end else begin
                            n_count = '0;
                            if (sh != zlhp_pkg::LOC_SIGNATURE) begin
                                n_halted          = 1'b1;
                                o_res_valid       = 1'b1;
                                o_res.kind        = zlhp_pkg::KIND_STOP;
                                o_res.stop_reason = zlhp_pkg::STOP_BAD_SIG;
                            end else begin
                                n_phase = zlhp_pkg::PH_HDR;
                            end
                        end
                    end
                    zlhp_pkg::PH_PREFIX: begin
                        n_remaining = r_remaining - 32'd1;
                        if (r_remaining == 32'd1) begin
                            n_phase = zlhp_pkg::PH_SIG;
                            n_count = '0;
                            n_shift = '0;
                        end
                    end
                    zlhp_pkg::PH_HDR: begin
                        n_count = r_count + 5'd1;
                        if (r_count == zlhp_pkg::HDR_FLAGS) begin
                            n_flags = sh[18:17];
                        end else if (r_count == zlhp_pkg::HDR_METHOD) begin
                            if (sh[31:16] > zlhp_pkg::METHOD_MAX) begin
                                n_halted          = 1'b1;
                                o_res_valid       = 1'b1;
                                o_res.kind        = zlhp_pkg::KIND_STOP;
                                o_res.stop_reason = zlhp_pkg::STOP_METHOD;
                            end else begin
                                n_method = map_method(sh[31:16], r_flags);
                            end
                        end else if (r_count == zlhp_pkg::HDR_PACKED) begin
                            n_packed = sh;
                        end else if (r_count == zlhp_pkg::HDR_PLAIN) begin
                            n_plain = sh;
                        end else if (r_count == zlhp_pkg::HDR_NAME_LEN) begin
                            if ({1'b0, sh[31:16]} >= 17'(NAME_LIMIT - 1)) begin
                                n_halted          = 1'b1;
                                o_res_valid       = 1'b1;
                                o_res.kind        = zlhp_pkg::KIND_STOP;
                                o_res.stop_reason = zlhp_pkg::STOP_NAME_LONG;
                            end else begin
                                n_name_len = sh[16 +: NAME_W];
                            end
                        end else if (r_count >= zlhp_pkg::HDR_EXTRA_LEN) begin
                            n_extra   = sh[31:16];
                            fin_extra = sh[31:16];
                            n_count   = '0;
                            if (r_name_len == '0) begin
                                do_finish = 1'b1;
                            end else begin
                                n_phase     = zlhp_pkg::PH_NAME;
                                n_remaining = 32'(r_name_len);
                            end
                        end
                    end
                    zlhp_pkg::PH_NAME: begin
                        n_remaining = r_remaining - 32'd1;
                        if (r_remaining == 32'd1) begin
                            do_finish = 1'b1;
                        end
                    end
                    zlhp_pkg::PH_EXTRA: begin
                        n_remaining = r_remaining - 32'd1;
                        if (r_remaining == 32'd1) begin
                            do_after = 1'b1;
                        end
                    end
                    zlhp_pkg::PH_DATA: begin
                        n_remaining = r_remaining - 32'd1;
                        if (r_remaining == 32'd1) begin
                            n_phase = zlhp_pkg::PH_SIG;
                            n_count = '0;
                            n_shift = '0;
                        end
                        if (r_stream_mode) begin
                            o_res_valid     = 1'b1;
                            o_res.kind      = zlhp_pkg::KIND_DATA;
                            o_res.data_byte = i_byte;
                            o_res.last_data = (r_remaining == 32'd1);
                        end
                    end
                    default: begin
                        n_phase = zlhp_pkg::PH_SIG;
                        n_count = '0;
                        n_shift = '0;
                    end
                endcase

                if (do_finish) begin
                    // directory entries with no data pass silently
                    if (!is_dir || r_phase != zlhp_pkg::PH_NAME) begin
                        o_res_valid       = 1'b1;
                        o_res.kind        = zlhp_pkg::KIND_ENTRY;
                        o_res.method_code = r_method;
                        o_res.packed_size = r_packed;
                        o_res.plain_size  = r_plain;
                        o_res.name_length = 13'(r_name_len);
                        o_res.data_offset = r_base_offset + n_pos + 32'(fin_extra);
                        n_prefix_ok       = 1'b0;
                    end
                    if (fin_extra != 16'd0) begin
                        n_phase     = zlhp_pkg::PH_EXTRA;
                        n_remaining = 32'(fin_extra);
                    end else begin
                        do_after = 1'b1;
                    end
                end

                if (do_after) begin
                    if (r_packed == 32'd0) begin
                        n_phase = zlhp_pkg::PH_SIG;
                        n_count = '0;
                        n_shift = '0;
                    end else begin
                        n_phase     = zlhp_pkg::PH_DATA;
                        n_remaining = r_packed;
                    end
                end
            end
        end
    end

    `ZLHP_ASSERT_NEXT(a_halt_sticky, i_clk, i_rst_n, r_halted, r_halted, "halt flag cleared")
    `ZLHP_ASSERT_NOW(a_no_result_halted, i_clk, i_rst_n, r_halted, !o_res_valid, "result while halted")
    `ZLHP_ASSERT_NEXT(a_stop_halts, i_clk, i_rst_n, o_res_valid && o_res.kind == zlhp_pkg::KIND_STOP, r_halted, "stop without halt")
    `ZLHP_ASSERT_NOW(a_count_nonzero, i_clk, i_rst_n, r_phase == zlhp_pkg::PH_PREFIX || r_phase == zlhp_pkg::PH_NAME || r_phase == zlhp_pkg::PH_EXTRA || r_phase == zlhp_pkg::PH_DATA, r_remaining != 32'd0, "byte counter empty in counted phase")

endmodule

[hw/rtl/zlhp_out_reg.sv]
// ----------------------------------------------------------------------------
// zlhp_out_reg
// Result register: holds one result word until the sink takes it and lets
// a new word load in the same cycle the old one leaves.
// ----------------------------------------------------------------------------
module zlhp_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_res_valid,
    input  zlhp_pkg::t_result  i_res,
    input  logic               i_out_ready,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output zlhp_pkg::t_result  o_res
);

    logic               r_valid, n_valid;
    zlhp_pkg::t_result  r_res, n_res;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    always_comb begin
        n_valid = r_valid;
        n_res   = r_res;
        if (r_valid && i_out_ready) begin
            n_valid = 1'b0;
        end
        if (i_load && i_res_valid) begin
            n_valid = 1'b1;
            n_res   = i_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

endmodule

[hw/rtl/zip_local_header_parser_top.sv]
// ----------------------------------------------------------------------------
// zip_local_header_parser_top
// ZIP local header parser: one archive byte in, entry, data and stop words out.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle and never stalls on its own: a byte is
// taken whenever the result register is empty or being drained, so the rate
// is one byte per clock while m_axis_tready stays high. A result appears in the
// cycle after the byte that causes it, from a single result register. Entry
// words come at the last name byte (last header byte if no name), data words
// per member byte in stream mode, a stop word on error or stream end; input
// is then discarded until reset. No memory, no clearing pass after reset.
// ----------------------------------------------------------------------------
module zip_local_header_parser_top #(
    parameter int NAME_LIMIT = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wen,
    input  logic                          i_cfg_addr,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // stream_byte
    input  logic                          s_axis_tuser,  // stream_end
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // method_code, packed_size, plain_size, name_length, data_offset,
    // data_byte, stop_reason, zero fill
    output logic [zlhp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // kind
    output logic                          m_axis_tlast   // last_data
);

    logic               accept;
    logic               res_valid;
    zlhp_pkg::t_result  res;
    zlhp_pkg::t_result  out_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    zlhp_parser #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (accept),
        .i_byte      (s_axis_tdata),
        .i_end       (s_axis_tuser),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    zlhp_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_res_valid (res_valid),
        .i_res       (res),
        .i_out_ready (m_axis_tready),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_res       (out_res)
    );

    assign m_axis_tdata = {5'd0, out_res.stop_reason, out_res.data_byte, out_res.data_offset,
                           out_res.name_length, out_res.plain_size, out_res.packed_size,
                           out_res.method_code};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.last_data;

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ZIP local header parser.
// ----------------------------------------------------------------------------
// Feeds archive bytes over the input stream and tracks the parse state in a
// local copy of the header walker. The copy predicts each output word:
// entry headers, passed-through member bytes and the final stop word.
// Directed archives cover the MacBinary prefix, data descriptors, every
// method code, directory entries, empty names and offset wrap. A random
// archive follows, then one randomly chosen way of stopping the parser.
// Both stream sides idle in random bursts; one long output stall fills the
// block. Each output word is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb;

    localparam int NAME_LIMIT   = 8192;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_BYTES = 240;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_wen;
    logic                           i_cfg_addr;
    logic [31:0]                    i_cfg_data;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [7:0]                     s_axis_tdata;
    logic                           s_axis_tuser;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [zlhp_pkg::TDATA_W-1:0]   m_axis_tdata;
    logic [1:0]                     m_axis_tuser;
    logic                           m_axis_tlast;

    zip_local_header_parser_top #(
        .NAME_LIMIT(NAME_LIMIT)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    zlhp_pkg::t_result  words_due[$];
    logic [7:0]         burst[$];
    int                 err_count  = 0;
    int                 bytes_sent = 0;
    bit                 idle_on    = 1'b1;
    bit                 hold_req   = 1'b0;
    logic               hold_on    = 1'b0;

    // parser copy
    bit                 cfg_mode;
    logic [31:0]        cfg_base;
    zlhp_pkg::t_phase   trk_phase;
    int                 trk_count;
    logic [31:0]        trk_shift;
    logic [15:0]        trk_flags;
    logic [3:0]         trk_method;
    logic [31:0]        trk_packed;
    logic [31:0]        trk_plain;
    logic [15:0]        trk_name_len;
    logic [15:0]        trk_extra_len;
    logic [31:0]        trk_left;
    logic [31:0]        trk_pos;
    bit                 trk_prefix_ok;
    logic [7:0]         trk_last_ch;
    bit                 trk_halted;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #30_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------ model

    task automatic reset_tracker();
        cfg_mode      = 1'b0;
        cfg_base      = '0;
        trk_phase     = zlhp_pkg::PH_SIG;
        trk_count     = 0;
        trk_shift     = '0;
        trk_flags     = '0;
        trk_method    = '0;
        trk_packed    = '0;
        trk_plain     = '0;
        trk_name_len  = '0;
        trk_extra_len = '0;
        trk_left      = '0;
        trk_pos       = '0;
        trk_prefix_ok = 1'b1;
        trk_last_ch   = '0;
        trk_halted    = 1'b0;
    endtask

    function automatic logic [3:0] method_code_of(input logic [15:0] m, input logic [15:0] f);
        if (m < zlhp_pkg::METHOD_IMPLODE)
            return m[3:0];
        if (m == zlhp_pkg::METHOD_IMPLODE) begin
            if (f[2])
                return f[1] ? zlhp_pkg::CODE_IMPLODE_LIT8 : zlhp_pkg::CODE_IMPLODE_LIT4;
            return f[1] ? zlhp_pkg::CODE_IMPLODE_NOLIT8 : zlhp_pkg::CODE_IMPLODE_NOLIT4;
        end
        return (m == zlhp_pkg::METHOD_RSVD) ? zlhp_pkg::CODE_RESERVED
                                            : zlhp_pkg::CODE_DEFLATED;
    endfunction

    task automatic stop_parse(input zlhp_pkg::t_stop why);
        zlhp_pkg::t_result w;
        w = '0;
        w.kind = zlhp_pkg::KIND_STOP;
        w.stop_reason = why;
        trk_halted = 1'b1;
        words_due.push_back(w);
    endtask

    task automatic restart_sig();
        trk_phase = zlhp_pkg::PH_SIG;
        trk_count = 0;
        trk_shift = '0;
    endtask

    task automatic leave_extra();
        if (trk_packed == 0) begin
            restart_sig();
        end else begin
            trk_phase = zlhp_pkg::PH_DATA;
            trk_left  = trk_packed;
        end
    endtask

    task automatic enter_extra();
        if (trk_extra_len == 0) begin
            leave_extra();
        end else begin
            trk_phase = zlhp_pkg::PH_EXTRA;
            trk_left  = {16'h0, trk_extra_len};
        end
    endtask

    task automatic close_name();
        zlhp_pkg::t_result w;
        if (trk_packed == 0 && trk_name_len != 0 &&
            (trk_last_ch == zlhp_pkg::CHAR_SLASH || trk_last_ch == zlhp_pkg::CHAR_BSLASH)) begin
            enter_extra();
        end else begin
            w = '0;
            w.kind        = zlhp_pkg::KIND_ENTRY;
            w.method_code = trk_method;
            w.packed_size = trk_packed;
            w.plain_size  = trk_plain;
            w.name_length = trk_name_len[12:0];
            w.data_offset = cfg_base + trk_pos + {16'h0, trk_extra_len};
            trk_prefix_ok = 1'b0;
            words_due.push_back(w);
            enter_extra();
        end
    endtask

    task automatic track_byte(input logic [7:0] b, input logic e);
        int                 idx;
        logic [15:0]        meth;
        zlhp_pkg::t_result  w;
        if (trk_halted) begin
        end else if (e) begin
            stop_parse(zlhp_pkg::STOP_STREAM_END);
        end else begin
            trk_pos   = trk_pos + 1;
            trk_shift = {b, trk_shift[31:8]};
            case (trk_phase)
                zlhp_pkg::PH_SIG: begin
                    if (trk_count != zlhp_pkg::SIG_LAST) begin
                        trk_count++;
                    end else begin
                        trk_count = 0;
                        if (trk_shift == zlhp_pkg::DESC_SIGNATURE) begin
                            trk_phase = zlhp_pkg::PH_DESC;
                        end else if (trk_prefix_ok &&
                                     trk_shift[7:0] == zlhp_pkg::PREFIX_MARK) begin
                            trk_prefix_ok = 1'b0;
                            trk_phase     = zlhp_pkg::PH_PREFIX;
                            trk_left      = zlhp_pkg::PREFIX_SKIP;
                        end else if (trk_shift != zlhp_pkg::LOC_SIGNATURE) begin
                            stop_parse(zlhp_pkg::STOP_BAD_SIG);
                        end else begin
                            trk_phase = zlhp_pkg::PH_HDR;
                        end
                    end
                end
                zlhp_pkg::PH_DESC: begin
                    if (trk_count != zlhp_pkg::DESC_LAST) begin
                        trk_count++;
                    end else begin
                        trk_count = 0;
                        if (trk_shift != zlhp_pkg::LOC_SIGNATURE)
                            stop_parse(zlhp_pkg::STOP_BAD_SIG);
                        else
                            trk_phase = zlhp_pkg::PH_HDR;
                    end
                end
                zlhp_pkg::PH_PREFIX: begin
                    trk_left = trk_left - 1;
                    if (trk_left == 0)
                        restart_sig();
                end
                zlhp_pkg::PH_HDR: begin
                    idx = trk_count;
                    trk_count++;
                    if (idx == zlhp_pkg::HDR_FLAGS) begin
                        trk_flags = trk_shift[31:16];
                    end else if (idx == zlhp_pkg::HDR_METHOD) begin
                        meth = trk_shift[31:16];
                        if (meth > zlhp_pkg::METHOD_MAX)
                            stop_parse(zlhp_pkg::STOP_METHOD);
                        else
                            trk_method = method_code_of(meth, trk_flags);
                    end else if (idx == zlhp_pkg::HDR_PACKED) begin
                        trk_packed = trk_shift;
                    end else if (idx == zlhp_pkg::HDR_PLAIN) begin
                        trk_plain = trk_shift;
                    end else if (idx == zlhp_pkg::HDR_NAME_LEN) begin
                        trk_name_len = trk_shift[31:16];
                        if (trk_name_len >= NAME_LIMIT - 1)
                            stop_parse(zlhp_pkg::STOP_NAME_LONG);
                    end else if (idx >= zlhp_pkg::HDR_EXTRA_LEN) begin
                        trk_extra_len = trk_shift[31:16];
                        trk_count     = 0;
                        trk_last_ch   = '0;
                        if (trk_name_len == 0) begin
                            close_name();
                        end else begin
                            trk_phase = zlhp_pkg::PH_NAME;
                            trk_left  = {16'h0, trk_name_len};
                        end
                    end
                end
                zlhp_pkg::PH_NAME: begin
                    trk_last_ch = b;
                    trk_left    = trk_left - 1;
                    if (trk_left == 0)
                        close_name();
                end
                zlhp_pkg::PH_EXTRA: begin
                    trk_left = trk_left - 1;
                    if (trk_left == 0)
                        leave_extra();
                end
                zlhp_pkg::PH_DATA: begin
                    trk_left = trk_left - 1;
                    if (trk_left == 0)
                        restart_sig();
                    if (cfg_mode) begin
                        w = '0;
                        w.kind      = zlhp_pkg::KIND_DATA;
                        w.data_byte = b;
                        w.last_data = (trk_left == 0);
                        words_due.push_back(w);
                    end
                end
                default: restart_sig();
            endcase
        end
    endtask

    // ------------------------------------------------------------- drivers

    task automatic send_word(input logic [7:0] b, input logic e);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= e;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        track_byte(b, e);
        bytes_sent++;
    endtask

    task automatic flush_burst(input int count);
        for (int i = 0; i < burst.size() && i < count; i++)
            send_word(burst[i], 1'b0);
        burst.delete();
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (words_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic addr, input logic [31:0] val);
        settle();
        i_cfg_wen  <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wen  <= 1'b0;
        if (addr == zlhp_pkg::CFG_STREAM_MODE)
            cfg_mode = val[0];
        else
            cfg_base = val;
    endtask

    task automatic add_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            burst.push_back(v[8*i +: 8]);
    endtask

    task automatic add_entry(input bit with_desc, input logic [15:0] flags,
                             input logic [15:0] meth, input logic [31:0] psize,
                             input logic [31:0] usize, input logic [15:0] nlen,
                             input logic [7:0] tail_ch, input logic [15:0] xlen,
                             input int data_len);
        if (with_desc) begin
            add_le(zlhp_pkg::DESC_SIGNATURE, 4);
            repeat (16) burst.push_back(8'($urandom));
        end
        add_le(zlhp_pkg::LOC_SIGNATURE, 4);
        add_le($urandom, 2);
        add_le({16'h0, flags}, 2);
        add_le({16'h0, meth}, 2);
        add_le($urandom, 4);
        add_le($urandom, 4);
        add_le(psize, 4);
        add_le(usize, 4);
        add_le({16'h0, nlen}, 2);
        add_le({16'h0, xlen}, 2);
        for (int i = 0; i < nlen; i++)
            burst.push_back(i == nlen - 1 ? tail_ch : 8'($urandom));
        repeat (xlen) burst.push_back(8'($urandom));
        repeat (data_len) burst.push_back(8'($urandom));
    endtask

    task automatic add_random_entry();
        logic [31:0] psize;
        logic [15:0] nlen;
        logic [15:0] xlen;
        logic [7:0]  tail_ch;
        case ($urandom_range(0, 9))
            0, 1, 2: psize = 0;
            9:       psize = $urandom_range(17, 48);
            default: psize = $urandom_range(1, 16);
        endcase
        nlen = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 10));
        case ($urandom_range(0, 3))
            0:       tail_ch = zlhp_pkg::CHAR_SLASH;
            1:       tail_ch = zlhp_pkg::CHAR_BSLASH;
            default: tail_ch = 8'($urandom);
        endcase
        xlen = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 6)) : 16'd0;
        add_entry($urandom_range(0, 9) == 0, 16'($urandom), 16'($urandom_range(0, 8)),
                  psize, $urandom, nlen, tail_ch, xlen, psize);
    endtask

    // ------------------------------------------------------------- checker

    task automatic flag_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
        $display("%0t ns: %0s mismatch, got %0h, want %0h", $time, what, got, want);
        err_count++;
    endtask

    always @(posedge i_clk) begin : check_words
        zlhp_pkg::t_result w;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (words_due.size() == 0) begin
                flag_mismatch("unexpected word", m_axis_tdata, '0);
            end else begin
                w = words_due.pop_front();
                if (m_axis_tuser !== w.kind)
                    flag_mismatch("kind", m_axis_tuser, w.kind);
                if (m_axis_tdata[3:0] !== w.method_code)
                    flag_mismatch("method_code", m_axis_tdata[3:0], w.method_code);
                if (m_axis_tdata[35:4] !== w.packed_size)
                    flag_mismatch("packed_size", m_axis_tdata[35:4], w.packed_size);
                if (m_axis_tdata[67:36] !== w.plain_size)
                    flag_mismatch("plain_size", m_axis_tdata[67:36], w.plain_size);
                if (m_axis_tdata[80:68] !== w.name_length)
                    flag_mismatch("name_length", m_axis_tdata[80:68], w.name_length);
                if (m_axis_tdata[112:81] !== w.data_offset)
                    flag_mismatch("data_offset", m_axis_tdata[112:81], w.data_offset);
                if (m_axis_tdata[120:113] !== w.data_byte)
                    flag_mismatch("data_byte", m_axis_tdata[120:113], w.data_byte);
                if (m_axis_tlast !== w.last_data)
                    flag_mismatch("last_data", m_axis_tlast, w.last_data);
                if (m_axis_tdata[122:121] !== w.stop_reason)
                    flag_mismatch("stop_reason", m_axis_tdata[122:121], w.stop_reason);
                if (m_axis_tdata[127:123] !== 5'h0)
                    flag_mismatch("zero fill", m_axis_tdata[127:123], 0);
            end
        end
    end

    // output side: random stalls, plus the long hold
    initial begin : sink
        int stall;
        stall = 0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_on) begin
                m_axis_tready <= 1'b0;
            end else if (stall > 0) begin
                m_axis_tready <= 1'b0;
                stall--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                stall = $urandom_range(0, 7);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : pressure
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_on <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_on <= 1'b0;
                hold_req = 1'b0;
            end
        end
    end

    // --------------------------------------------------------------- tests

    task automatic test_prefix_skip();
        set_reg(zlhp_pkg::CFG_STREAM_MODE, 32'd0);
        set_reg(zlhp_pkg::CFG_BASE_OFFSET, 32'd0);
        burst.push_back(zlhp_pkg::PREFIX_MARK);
        repeat (127) burst.push_back(8'($urandom));
        add_entry(1'b0, 16'h0000, 16'd0, 32'd3, 32'd3, 16'd4, 8'h61, 16'd0, 3);
        // empty name, result lands on the extra length
        add_entry(1'b0, 16'h0000, 16'd8, 32'd5, 32'd0, 16'd0, 8'h00, 16'd3, 5);
        flush_burst(burst.size());
    endtask

    task automatic test_method_codes();
        logic [15:0] flags;
        for (int m = 0; m <= zlhp_pkg::METHOD_MAX; m++) begin
            if (m == zlhp_pkg::METHOD_IMPLODE) begin
                for (int f = 0; f < 4; f++) begin
                    flags = 16'($urandom) & 16'hfff9 | 16'(f << 1);
                    add_entry(1'b0, flags, 16'(m), 32'd1, $urandom, 16'd2, 8'h41,
                              16'd0, 1);
                end
            end else begin
                flags = (m == 0) ? 16'h0000 :
                        (m == zlhp_pkg::METHOD_MAX) ? 16'hffff : 16'($urandom);
                add_entry(1'b0, flags, 16'(m), 32'(m % 3), (m % 2) ? 32'hffff_ffff : 32'd0,
                          16'd1, 8'h7a, 16'd1, m % 3);
            end
        end
        flush_burst(burst.size());
    endtask

    task automatic test_descriptor();
        add_entry(1'b1, 16'h0008, 16'd8, 32'd2, 32'd9, 16'd3, 8'h62, 16'd0, 2);
        add_entry(1'b1, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd2, 8'h63, 16'd2, 0);
        flush_burst(burst.size());
    endtask

    task automatic test_directory();
        add_entry(1'b0, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd3, zlhp_pkg::CHAR_SLASH, 16'd2, 0);
        add_entry(1'b0, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd1, zlhp_pkg::CHAR_BSLASH, 16'd0, 0);
        add_entry(1'b0, 16'h0000, 16'd0, 32'd2, 32'd2, 16'd2, zlhp_pkg::CHAR_SLASH, 16'd0, 2);
        add_entry(1'b0, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd2, 8'h2e, 16'd1, 0);
        add_entry(1'b0, 16'h0000, 16'd0, 32'd0, 32'd0, 16'd0, 8'h00, 16'd0, 0);
        flush_burst(burst.size());
    endtask

    task automatic test_offset_extremes();
        set_reg(zlhp_pkg::CFG_BASE_OFFSET, 32'hffff_ffff);
        add_entry(1'b0, 16'h0000, 16'd1, 32'd1, 32'd1, 16'd1, 8'h78, 16'd0, 1);
        flush_burst(burst.size());
        set_reg(zlhp_pkg::CFG_BASE_OFFSET, 32'hffff_fff0);
        // offset wraps past the top with name and extra field added
        add_entry(1'b0, 16'h0000, 16'd0, 32'd1, 32'd1, 16'd5, 8'h79, 16'd40, 1);
        flush_burst(burst.size());
        set_reg(zlhp_pkg::CFG_BASE_OFFSET, $urandom);
    endtask

    task automatic test_data_pass();
        set_reg(zlhp_pkg::CFG_STREAM_MODE, 32'd1);
        hold_req = 1'b1;
        add_entry(1'b0, 16'h0000, 16'd0, 32'd64, 32'd64, 16'd2, 8'h64, 16'd0, 64);
        add_entry(1'b0, 16'h0000, 16'd8, 32'd1, 32'd7, 16'd0, 8'h00, 16'd1, 1);
        add_entry(1'b1, 16'h0000, 16'd8, 32'd3, 32'd7, 16'd1, 8'h65, 16'd0, 3);
        flush_burst(burst.size());
    endtask

    task automatic test_random_archive();
        int start;
        int entries;
        start   = bytes_sent;
        entries = 0;
        while (bytes_sent - start < RANDOM_BYTES) begin
            if (bytes_sent - start > RANDOM_BYTES * 3 / 4)
                idle_on = 1'b0;
            if (entries % 3 == 2) begin
                set_reg(zlhp_pkg::CFG_STREAM_MODE, $urandom_range(0, 1));
                case ($urandom_range(0, 3))
                    0:       set_reg(zlhp_pkg::CFG_BASE_OFFSET, 32'd0);
                    1:       set_reg(zlhp_pkg::CFG_BASE_OFFSET, 32'hffff_ffff);
                    default: set_reg(zlhp_pkg::CFG_BASE_OFFSET, $urandom);
                endcase
            end
            add_random_entry();
            flush_burst(burst.size());
            entries++;
        end
    endtask

    task automatic test_stop();
        zlhp_pkg::t_stop why;
        idle_on = 1'b0;
        why = zlhp_pkg::t_stop'($urandom_range(0, 3));
        case (why)
            zlhp_pkg::STOP_BAD_SIG: begin
                burst.push_back(8'($urandom_range(8'h51, 8'hff)));
                repeat (3) burst.push_back(8'($urandom));
                flush_burst(burst.size());
            end
            zlhp_pkg::STOP_METHOD: begin
                add_entry(1'b0, 16'($urandom), 16'($urandom_range(9, 65535)), 32'd0,
                          32'd0, 16'd1, 8'h41, 16'd0, 0);
                flush_burst(burst.size());
            end
            zlhp_pkg::STOP_NAME_LONG: begin
                add_entry(1'b0, 16'($urandom), 16'd0, 32'd0, 32'd0,
                          16'($urandom_range(NAME_LIMIT - 1, 65535)), 8'h41, 16'd0, 0);
                flush_burst(30);
            end
            default: begin
                add_entry(1'b0, 16'($urandom), 16'd8,
                          $urandom_range(0, 1) ? 32'hffff_ffff : $urandom, 32'hffff_ffff,
                          16'd3, 8'h66, 16'd2, 20);
                flush_burst($urandom_range(0, burst.size()));
                send_word(8'($urandom), 1'b1);
            end
        endcase
        // parser is halted now; all of these are dropped
        repeat (3) send_word(8'($urandom), 1'b0);
        send_word(8'($urandom), 1'b1);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_wen     <= 1'b0;
        i_cfg_addr    <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        reset_tracker();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_prefix_skip();
        test_method_codes();
        test_descriptor();
        test_directory();
        test_offset_extremes();
        test_data_pass();
        test_random_archive();
        test_stop();

        settle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
